// File: hdl/xtea_pkg.sv
// Shared types and constants for the XTEA block cipher pipeline.
package xtea_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned KEY_WORDS = 4;

    // Round constant: the sum moves by DELTA per round (same as minus NEG_DELTA)
    localparam logic [WORD_W-1:0] XTEA_NEG_DELTA = 32'h61C8_8647;
    localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;
    // Decryption start sum for the standard 32-round cipher
    localparam logic [WORD_W-1:0] XTEA_DEC_START_32 = 32'hC6EF_3720;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_KEY_ZERO  = 2'd0,
        REG_KEY_ONE   = 2'd1,
        REG_KEY_TWO   = 2'd2,
        REG_KEY_THREE = 2'd3
    } cfg_reg_t;

    // Block request on the input channel
    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } blk_t;

    // Transformed block on the output channel
    typedef struct packed {
        logic [WORD_W-1:0] first_result;
        logic [WORD_W-1:0] second_result;
    } rslt_t;

    // Working state carried down the pipeline
    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
    } xtea_state_t;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

    // Feistel mixing function
    function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

// File: hdl/xtea_round.sv
// One half-round pipeline stage: updates one block word, encrypt or decrypt.
module xtea_round (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                even_stage,
    input  logic [31:0]         enc_sum,
    input  logic [31:0]         dec_sum,
    input  xtea_pkg::key_t      key,
    input  logic                valid_in,
    input  xtea_pkg::xtea_state_t state_in,
    output logic                valid_out,
    output xtea_pkg::xtea_state_t state_out
);
    import xtea_pkg::*;

    logic                valid_reg;
    xtea_state_t         state_reg;
    xtea_state_t         state_next;
    logic                dec;
    logic                upd_first;
    logic [WORD_W-1:0]   sum;
    logic [1:0]          kidx;
    logic [WORD_W-1:0]   src;
    logic [WORD_W-1:0]   tgt;
    logic [WORD_W-1:0]   f_val;
    logic [WORD_W-1:0]   upd_val;

    // Encrypt updates v0 on even stages; decrypt runs the halves in reverse
    always_comb
    begin
        dec        = state_in.action;
        upd_first  = even_stage ^ dec;
        sum        = dec ? dec_sum : enc_sum;
        kidx       = upd_first ? sum[1:0] : sum[12:11];
        src        = upd_first ? state_in.v1 : state_in.v0;
        tgt        = upd_first ? state_in.v0 : state_in.v1;
        f_val      = mix_word(src) ^ (sum + key[kidx]);
        upd_val    = dec ? (tgt - f_val) : (tgt + f_val);
        state_next = state_in;
        if (upd_first)
        begin
            state_next.v0 = upd_val;
        end
        else
        begin
            state_next.v1 = upd_val;
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule

// File: hdl/xtea_outbuf.sv
// Output register with skid stage; holds the pipeline when both are full.
module xtea_outbuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  xtea_pkg::xtea_state_t push_state,
    output logic                  full,
    output logic                  rslt_valid,
    input  logic                  rslt_ready,
    output xtea_pkg::rslt_t       rslt
);
    import xtea_pkg::*;

    logic  out_valid_reg;
    logic  out_valid_next;
    logic  skid_valid_reg;
    logic  skid_valid_next;
    rslt_t out_reg;
    rslt_t out_next;
    rslt_t skid_reg;
    rslt_t skid_next;
    rslt_t push_rslt;
    logic  pop;

    assign push_rslt = '{first_result: push_state.v0, second_result: push_state.v1};
    assign pop       = out_valid_reg && rslt_ready;

    // Next-state for output and skid registers
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg)
        begin
            out_valid_next = push;
            out_next       = push_rslt;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_next       = push_rslt;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_rslt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full       = skid_valid_reg;
    assign rslt_valid = out_valid_reg;
    assign rslt       = out_reg;

    // Skid stage is only used behind an occupied output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while output register is empty");

    // A result arriving at a blocked output must land in the skid stage
    a_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !rslt_ready) |=> skid_valid_reg)
        else $error("result pushed into blocked output was not captured");

    // Pipeline must not push while the skid stage is full
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("push into full output buffer");

    // Draining the skid stage empties it
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && skid_valid_reg) |=> !skid_valid_reg)
        else $error("skid stage not released after output taken");

endmodule

// File: hdl/xtea_block_cipher.sv
// XTEA block cipher top level: key registers, unrolled round pipeline, output buffer.
// A request passes through every half-round stage register and then the output register before its result is valid.
// Throughput: one block per cycle unless the output skid stage is full; each half-round is one pipeline stage.
// The pipeline holds only while the output skid stage is full (two results waiting).
// Reset (rst_n, async, active low) clears all valid bits and the key to zero.
module xtea_block_cipher #(
    parameter int ROUND_COUNT = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration write port
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    // block requests
    input  logic                blk_valid,
    output logic                blk_ready,
    input  xtea_pkg::blk_t      blk,
    // results
    output logic                rslt_valid,
    input  logic                rslt_ready,
    output xtea_pkg::rslt_t     rslt
);
    import xtea_pkg::*;

    localparam int STAGES = 2 * ROUND_COUNT;

    key_t        key_reg;
    logic        en;
    logic        buf_full;
    logic        stg_valid [STAGES+1];
    xtea_state_t stg_state [STAGES+1];

    // Key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_KEY_ZERO:  key_reg[0] <= cfg_data;
                REG_KEY_ONE:   key_reg[1] <= cfg_data;
                REG_KEY_TWO:   key_reg[2] <= cfg_data;
                REG_KEY_THREE: key_reg[3] <= cfg_data;
                default:       key_reg    <= key_reg;
            endcase
        end
    end

    // Pipeline advances unless the output buffer is full
    assign en        = !buf_full;
    assign blk_ready = en;

    assign stg_valid[0] = blk_valid;
    assign stg_state[0] = '{action: blk.action, v0: blk.first_word, v1: blk.second_word};

    // Unrolled half-round stages with per-stage constant sums
    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        localparam int RND = j / 2;
        localparam int ENC_STEPS = (j % 2 == 0) ? RND : RND + 1;
        localparam int DEC_STEPS = (j % 2 == 0) ? ROUND_COUNT - RND : ROUND_COUNT - RND - 1;
        localparam logic [63:0] ENC_PROD = 64'(XTEA_DELTA) * 64'(ENC_STEPS);
        localparam logic [63:0] DEC_PROD = 64'(XTEA_DELTA) * 64'(DEC_STEPS);
        localparam logic [31:0] ENC_SUM = ENC_PROD[31:0];
        localparam logic [31:0] DEC_SUM = DEC_PROD[31:0];

        xtea_round u_round (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .even_stage ((j % 2) == 0),
            .enc_sum    (ENC_SUM),
            .dec_sum    (DEC_SUM),
            .key        (key_reg),
            .valid_in   (stg_valid[j]),
            .state_in   (stg_state[j]),
            .valid_out  (stg_valid[j+1]),
            .state_out  (stg_state[j+1])
        );
    end

    // Output register and skid stage
    xtea_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (en && stg_valid[STAGES]),
        .push_state (stg_state[STAGES]),
        .full       (buf_full),
        .rslt_valid (rslt_valid),
        .rslt_ready (rslt_ready),
        .rslt       (rslt)
    );

endmodule

// File: tb/xtea_block_cipher_test.sv
// Self-checking testbench for the XTEA block cipher pipeline: queued driver, scoreboard monitor.
`timescale 1ns / 1ps

module xtea_block_cipher_test;
    import xtea_pkg::*;

    localparam int ROUNDS = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 2 * ROUNDS + 16;
    localparam int RANDOM_PHASE_ITEMS = 50;
    localparam int REPORT_LIMIT = 10;

    // Request action codes
    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_KEY_ZERO;
    logic [31:0] cfg_data = '0;
    logic        blk_valid = 1'b0;
    logic        blk_ready;
    blk_t        blk = '0;
    logic        rslt_valid;
    logic        rslt_ready = 1'b0;
    rslt_t       rslt;

    blk_t  pending_blocks[$];
    rslt_t expected_blocks[$];
    key_t  key_copy = '0;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    int    fail_count = 0;
    int    cycle_count = 0;
    rslt_t want;

    xtea_block_cipher #(
        .ROUND_COUNT(ROUNDS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .blk_valid(blk_valid),
        .blk_ready(blk_ready),
        .blk(blk),
        .rslt_valid(rslt_valid),
        .rslt_ready(rslt_ready),
        .rslt(rslt)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Expected cipher output for one request under the given key
    function automatic rslt_t xtea_cipher(input blk_t req, input key_t key);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] sum;
        rslt_t       res;
        v0 = req.first_word;
        v1 = req.second_word;
        if (req.action == ACT_DECRYPT)
        begin
            // start from the sum left after the last encryption round
            sum = XTEA_DELTA * ROUNDS;
            for (int r = 0; r < ROUNDS; r++)
            begin
                v1 = v1 - ((((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + key[sum[12:11]]));
                sum = sum + XTEA_NEG_DELTA;
                v0 = v0 - ((((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + key[sum[1:0]]));
            end
        end
        else
        begin
            sum = '0;
            for (int r = 0; r < ROUNDS; r++)
            begin
                v0 = v0 + ((((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + key[sum[1:0]]));
                sum = sum - XTEA_NEG_DELTA;
                v1 = v1 + ((((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + key[sum[12:11]]));
            end
        end
        res.first_result = v0;
        res.second_result = v1;
        return res;
    endfunction

    function automatic blk_t make_block(input logic act, input logic [31:0] w0,
                                        input logic [31:0] w1);
        blk_t b;
        b.action = act;
        b.first_word = w0;
        b.second_word = w1;
        return b;
    endfunction

    // Queue an encryption and then the decryption of its predicted ciphertext
    task automatic queue_round_trip(input logic [31:0] w0, input logic [31:0] w1);
        rslt_t enc;
        enc = xtea_cipher(make_block(ACT_ENCRYPT, w0, w1), key_copy);
        pending_blocks.push_back(make_block(ACT_ENCRYPT, w0, w1));
        pending_blocks.push_back(make_block(ACT_DECRYPT, enc.first_result, enc.second_result));
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        key_copy[idx] = value;
    endtask

    // Load all four key words back to back, write enable held high throughout
    task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
        write_reg(REG_KEY_THREE, k3);
        write_reg(REG_KEY_ONE, k1);
        write_reg(REG_KEY_ZERO, k0);
        write_reg(REG_KEY_TWO, k2);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every queued request went in and every result came back
    task automatic drain();
        do
            @(negedge clk);
        while (pending_blocks.size() != 0 || blk_valid || expected_blocks.size() != 0);
    endtask

    task automatic run_random_phase(input int send_pct, input int rx_pct);
        int n;
        @(negedge clk);
        send_idle_pct = send_pct;
        stall_pct = rx_pct;
        n = 0;
        while (n < RANDOM_PHASE_ITEMS)
        begin
            if ($urandom_range(7) == 0)
            begin
                queue_round_trip($urandom, $urandom);
                n += 2;
            end
            else
            begin
                pending_blocks.push_back(make_block(1'($urandom_range(1)), $urandom, $urandom));
                n++;
            end
        end
        drain();
    endtask

    task automatic report_mismatch(input string what, input rslt_t exp_r, input rslt_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%s: expected %h %h, got %h %h", what, exp_r.first_result,
                     exp_r.second_result, got.first_result, got.second_result);
    endtask

    // Request driver: presents queued blocks, predicts the result at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid <= 1'b0;
            blk <= '0;
        end
        else
        begin
            if (blk_valid && blk_ready)
                expected_blocks.push_back(xtea_cipher(blk, key_copy));
            if (!blk_valid || blk_ready)
            begin
                if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    blk <= pending_blocks.pop_front();
                    blk_valid <= 1'b1;
                end
                else
                    blk_valid <= 1'b0;
            end
        end
    end

    // Result monitor: random backpressure, in-order compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rslt_ready <= 1'b0;
        else
        begin
            if (rslt_valid && rslt_ready)
            begin
                if (expected_blocks.size() == 0)
                    report_mismatch("unexpected result", '0, rslt);
                else
                begin
                    want = expected_blocks.pop_front();
                    if (rslt.first_result !== want.first_result ||
                        rslt.second_result !== want.second_result)
                        report_mismatch("result mismatch", want, rslt);
                end
            end
            rslt_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Phase sequencer
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset key, never written: extremes of both block words, both actions
        @(negedge clk);
        pending_blocks.push_back(make_block(ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000));
        pending_blocks.push_back(make_block(ACT_DECRYPT, 32'h0000_0000, 32'h0000_0000));
        pending_blocks.push_back(make_block(ACT_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_blocks.push_back(make_block(ACT_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_blocks.push_back(make_block(ACT_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF));
        pending_blocks.push_back(make_block(ACT_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000));
        pending_blocks.push_back(make_block(ACT_ENCRYPT, 32'h8000_0000, 32'h0000_0001));
        pending_blocks.push_back(make_block(ACT_DECRYPT, 32'h0000_0001, 32'h8000_0000));
        drain();

        // All-ones key, extremes again plus round trips
        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        @(negedge clk);
        pending_blocks.push_back(make_block(ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000));
        pending_blocks.push_back(make_block(ACT_DECRYPT, 32'h0000_0000, 32'h0000_0000));
        pending_blocks.push_back(make_block(ACT_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_blocks.push_back(make_block(ACT_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_blocks.push_back(make_block(ACT_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000));
        pending_blocks.push_back(make_block(ACT_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF));
        queue_round_trip(32'h0123_4567, 32'h89AB_CDEF);
        queue_round_trip(32'hFFFF_FFFF, 32'h0000_0000);
        drain();

        // One-hot key words, then random phases under every idling mode
        load_key(32'h0000_0001, 32'h8000_0000, 32'h0001_0000, 32'h0000_8000);
        @(negedge clk);
        queue_round_trip(32'h0000_0000, 32'h0000_0000);
        drain();

        load_key($urandom, $urandom, $urandom, $urandom);
        run_random_phase(0, 0);
        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random_phase(50, 0);
        load_key($urandom, $urandom, $urandom, $urandom);
        run_random_phase(0, 50);
        load_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        run_random_phase(29, 29);
        load_key($urandom, $urandom, $urandom, $urandom);
        run_random_phase(0, 0);
        load_key(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h0000_0001);
        run_random_phase(50, 0);
        load_key($urandom, $urandom, $urandom, $urandom);
        run_random_phase(0, 50);
        load_key($urandom, $urandom, $urandom, $urandom);
        run_random_phase(29, 29);

        // Tail: give a misbehaving pipeline the chance to emit strays
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && expected_blocks.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
